@@ hdl/isms_pkg.sv @@
// ----------------------------------------------------------------------------
// isms_pkg
// Shared types and constants for the interval set merge/insert unit: cell
// operation codes, the controller state type and the cell link structures.
// ----------------------------------------------------------------------------
package isms_pkg;

  localparam int NUM_CELLS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int COUNT_W   = $clog2(NUM_CELLS + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INSERT,
    CELL_MERGE,
    CELL_SHIFT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACT,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  key_beg;
    logic signed [DATA_W-1:0]  key_end;
    logic signed [DATA_W-1:0]  mrg_beg;
    logic signed [DATA_W-1:0]  mrg_end;
  } cell_ctl_t;

  // What one cell shows its neighbors and the controller.
  typedef struct packed {
    logic signed [DATA_W-1:0]  ibeg;
    logic signed [DATA_W-1:0]  iend;
    logic                      pos;    // at or after the insert position
    logic                      touch;  // overlaps or abuts the key range
    logic                      dead;   // absorbed, waiting to be squeezed out
  } cell_link_t;

  localparam cell_link_t EDGE_LINK = '0;

endpackage

@@ hdl/isms_cell.sv @@
// ----------------------------------------------------------------------------
// isms_cell
// One table slot: holds one interval, compares it against the key range and
// moves data to or from its neighbors during insert and compaction.
// ----------------------------------------------------------------------------
module isms_cell
  import isms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic       occupied,
  input  cell_link_t prev,
  input  cell_link_t next,
  output cell_link_t link
);

  logic signed [DATA_W-1:0] ibeg;
  logic signed [DATA_W-1:0] iend;
  logic                     below;
  logic                     touch;
  logic                     dead;

  logic signed [DATA_W:0]   beg_x;
  logic signed [DATA_W:0]   end_x;
  logic signed [DATA_W:0]   key_lo;
  logic signed [DATA_W:0]   key_hi;
  logic                     below_c;
  logic                     touch_c;

  // Adjacency is tested one bit wider so the extreme values do not wrap.
  always_comb begin
    beg_x   = {ibeg[DATA_W-1], ibeg};
    end_x   = {iend[DATA_W-1], iend};
    key_lo  = {ctl.key_beg[DATA_W-1], ctl.key_beg} - (DATA_W+1)'(1);
    key_hi  = {ctl.key_end[DATA_W-1], ctl.key_end} + (DATA_W+1)'(1);
    below_c = occupied && (end_x < key_lo);
    touch_c = occupied && !(end_x < key_lo) && (beg_x <= key_hi);
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (!below) begin
          if (prev.pos) begin
            ibeg <= prev.ibeg;
            iend <= prev.iend;
          end else begin
            ibeg <= ctl.key_beg;
            iend <= ctl.key_end;
          end
        end
      end
      CELL_MERGE: begin
        if (touch && !prev.touch) begin
          ibeg <= ctl.mrg_beg;
          iend <= ctl.mrg_end;
        end
      end
      CELL_SHIFT: begin
        if (prev.pos) begin
          ibeg <= next.ibeg;
          iend <= next.iend;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      below <= 1'b0;
      touch <= 1'b0;
      dead  <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_CMP: begin
          below <= below_c;
          touch <= touch_c;
        end
        CELL_MERGE: dead <= touch && prev.touch;
        CELL_SHIFT: begin
          if (prev.pos) begin
            dead <= next.dead;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign link = '{ibeg: ibeg, iend: iend, pos: !below, touch: touch, dead: dead};

endmodule

@@ hdl/interval_set_merge_insert_unit.sv @@
// ----------------------------------------------------------------------------
// interval_set_merge_insert_unit
// Sorted table of disjoint, non-adjacent intervals kept in a row of cells.
// An insert absorbs every interval that overlaps or abuts the new range;
// a read returns the entry at an index.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | cmd, range_begin, range_end, entry_index
//   out     | out_valid / out_ready| out_begin, out_end, interval_count,
//           |                      | entry_valid, table_full, bad_range
//
// A read, a rejected insert or an insert of a new interval steps through the
// compare, act and done states. An insert that absorbs stored intervals also
// passes the shift state: the cells squeeze out one absorbed slot per cycle.
// One item is in work at a time; a result waiting in the output register
// does not stop the next input transfer, only the delivery of its result.
// Reset is synchronous; the table is empty afterwards.
// ----------------------------------------------------------------------------
module interval_set_merge_insert_unit
  import isms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     cmd,
  input  logic signed [DATA_W-1:0] range_begin,
  input  logic signed [DATA_W-1:0] range_end,
  input  logic [IDX_W-1:0]         entry_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_begin,
  output logic signed [DATA_W-1:0] out_end,
  output logic [COUNT_W-1:0]       interval_count,
  output logic                     entry_valid,
  output logic                     table_full,
  output logic                     bad_range
);

  state_t                   state;
  state_t                   state_next;
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;

  logic                     cmd_q;
  logic signed [DATA_W-1:0] key_beg;
  logic signed [DATA_W-1:0] key_end;
  logic [IDX_W-1:0]         idx_q;

  logic signed [DATA_W-1:0] res_beg;
  logic signed [DATA_W-1:0] res_end;
  logic                     res_valid;
  logic                     res_full;
  logic                     res_bad;

  cell_ctl_t                ctl;
  cell_op_t                 op;
  cell_link_t               links [NUM_CELLS];
  cell_link_t               link_out_w [NUM_CELLS];
  logic [NUM_CELLS-1:0]     occ;
  logic [NUM_CELLS-1:0]     touch_v;
  logic [NUM_CELLS-1:0]     dead_v;

  logic signed [DATA_W-1:0] first_beg;
  logic signed [DATA_W-1:0] last_end;
  logic signed [DATA_W-1:0] mrg_beg;
  logic signed [DATA_W-1:0] mrg_end;
  logic signed [DATA_W-1:0] rd_beg;
  logic signed [DATA_W-1:0] rd_end;
  logic                     rd_hit;
  logic                     any_touch;
  logic                     any_dead;
  logic                     is_full;
  logic                     reversed;
  logic                     load_out;

  // ---------------------------------------------------------------- cells
  genvar g;
  generate
    for (g = 0; g < NUM_CELLS; g++) begin : g_cell
      cell_link_t prev_l;
      cell_link_t next_l;

      if (g == 0) begin : g_first
        assign prev_l = EDGE_LINK;
      end else begin : g_mid_lo
        assign prev_l = links[g-1];
      end
      if (g == NUM_CELLS - 1) begin : g_last
        assign next_l = EDGE_LINK;
      end else begin : g_mid_hi
        assign next_l = links[g+1];
      end

      assign occ[g]     = count > COUNT_W'(g);
      assign touch_v[g] = links[g].touch;
      assign dead_v[g]  = links[g].dead;

      isms_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .occupied (occ[g]),
        .prev     (prev_l),
        .next     (next_l),
        .link     (link_out_w[g])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      links[i] = link_out_w[i];
    end
  end

  // ------------------------------------------------- selection across cells
  always_comb begin
    first_beg = '0;
    last_end  = '0;
    rd_beg    = '0;
    rd_end    = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (touch_v[i] && (i == 0 || !touch_v[(i == 0) ? 0 : i-1])) begin
        first_beg = first_beg | links[i].ibeg;
      end
      if (touch_v[i] && (i == NUM_CELLS-1 || !touch_v[(i == NUM_CELLS-1) ? i : i+1])) begin
        last_end = last_end | links[i].iend;
      end
      if (COUNT_W'(i) == COUNT_W'(idx_q)) begin
        rd_beg = links[i].ibeg;
        rd_end = links[i].iend;
      end
    end
  end

  assign any_touch = |touch_v;
  assign any_dead  = |dead_v;
  assign is_full   = count == COUNT_W'(NUM_CELLS);
  assign reversed  = key_beg > key_end;
  assign rd_hit    = COUNT_W'(idx_q) < count;
  assign mrg_beg   = (first_beg < key_beg) ? first_beg : key_beg;
  assign mrg_end   = (last_end > key_end) ? last_end : key_end;
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  assign ctl = '{op: op, key_beg: key_beg, key_end: key_end,
                 mrg_beg: mrg_beg, mrg_end: mrg_end};

  // ------------------------------------------------------------ controller
  always_comb begin
    state_next = state;
    op         = CELL_HOLD;
    count_next = count;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        op         = CELL_CMP;
        state_next = ST_ACT;
      end
      ST_ACT: begin
        state_next = ST_DONE;
        if (cmd_q == CMD_INSERT && !reversed) begin
          if (any_touch) begin
            op         = CELL_MERGE;
            state_next = ST_SHIFT;
          end else if (!is_full) begin
            op         = CELL_INSERT;
            count_next = count + COUNT_W'(1);
          end
        end
      end
      ST_SHIFT: begin
        if (any_dead) begin
          op         = CELL_SHIFT;
          count_next = count - COUNT_W'(1);
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q   <= cmd;
      key_beg <= range_begin;
      key_end <= range_end;
      idx_q   <= entry_index;
    end
    if (state == ST_ACT) begin
      res_beg   <= '0;
      res_end   <= '0;
      res_valid <= 1'b0;
      res_full  <= 1'b0;
      res_bad   <= 1'b0;
      if (cmd_q == CMD_READ) begin
        if (rd_hit) begin
          res_beg   <= rd_beg;
          res_end   <= rd_end;
          res_valid <= 1'b1;
        end
      end else if (reversed) begin
        res_bad <= 1'b1;
      end else if (any_touch) begin
        res_beg   <= mrg_beg;
        res_end   <= mrg_end;
        res_valid <= 1'b1;
      end else if (is_full) begin
        res_full <= 1'b1;
      end else begin
        res_beg   <= key_beg;
        res_end   <= key_end;
        res_valid <= 1'b1;
      end
    end
    if (load_out) begin
      out_begin      <= res_beg;
      out_end        <= res_end;
      interval_count <= count;
      entry_valid    <= res_valid;
      table_full     <= res_full;
      bad_range      <= res_bad;
    end
  end

  assign in_ready = state == ST_IDLE;

endmodule

@@ hdl/isms_checker.sv @@
// ----------------------------------------------------------------------------
// isms_checker
// Port-level checks for the interval set merge/insert unit, bound to the top.
// ----------------------------------------------------------------------------
module isms_checker
  import isms_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_begin,
  input logic signed [DATA_W-1:0] out_end,
  input logic [COUNT_W-1:0]       interval_count,
  input logic                     entry_valid,
  input logic                     table_full,
  input logic                     bad_range
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_begin) && $stable(out_end)
      && $stable(interval_count) && $stable(entry_valid))
    else $error("result changed while stalled");

  // A good result never carries an error flag, and the two flags exclude.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(entry_valid && (table_full || bad_range)) && !(table_full && bad_range))
    else $error("inconsistent result flags");

  // Every interval handed out is well ordered.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> out_begin <= out_end)
    else $error("interval with begin above end");

  // The count never exceeds the table size; a dropped insert implies a full table.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (interval_count <= COUNT_W'(NUM_CELLS))
      && (!table_full || interval_count == COUNT_W'(NUM_CELLS)))
    else $error("bad interval count");

  // Nothing is shown the cycle after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind interval_set_merge_insert_unit isms_checker u_isms_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_begin      (out_begin),
  .out_end        (out_end),
  .interval_count (interval_count),
  .entry_valid    (entry_valid),
  .table_full     (table_full),
  .bad_range      (bad_range)
);
